FILE: rtl/vrp_pkg.sv
`default_nettype none

package vrp_pkg;

	localparam int ANGLE_W     = 6;
	localparam int TRIG_W      = 10;
	localparam int TRIG_SHIFT  = 8;
	localparam int TRIG_ONE    = 256;
	localparam int PERSP_NUM   = 25600;
	localparam int PERSP_BASE  = 110;
	localparam int QUOT_W      = 15;
	localparam int DIV_BPS     = 3;
	localparam int DEPTH_W     = 16;
	localparam int PIXEL_W     = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ANGLE_X      = 3'd0,
		REG_ANGLE_Y      = 3'd1,
		REG_ANGLE_Z      = 3'd2,
		REG_CENTER_X     = 3'd3,
		REG_CENTER_Y     = 3'd4,
		REG_DEPTH_OFFSET = 3'd5
	} cfg_reg_t;

	// quarter-wave cosine, 16 steps per quadrant, scaled by 256
	function automatic logic [TRIG_W-2:0] qwave(input logic [4:0] step);
		logic [TRIG_W-2:0] v;
		case (step)
			5'd0:    v = 9'd256;
			5'd1:    v = 9'd254;
			5'd2:    v = 9'd251;
			5'd3:    v = 9'd244;
			5'd4:    v = 9'd236;
			5'd5:    v = 9'd225;
			5'd6:    v = 9'd212;
			5'd7:    v = 9'd197;
			5'd8:    v = 9'd181;
			5'd9:    v = 9'd162;
			5'd10:   v = 9'd142;
			5'd11:   v = 9'd120;
			5'd12:   v = 9'd97;
			5'd13:   v = 9'd74;
			5'd14:   v = 9'd49;
			5'd15:   v = 9'd25;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [TRIG_W-1:0] trig_cos(input logic [ANGLE_W-1:0] angle);
		logic signed [TRIG_W-1:0] fwd;
		logic signed [TRIG_W-1:0] rev;
		logic signed [TRIG_W-1:0] v;
		fwd = $signed({1'b0, qwave({1'b0, angle[3:0]})});
		rev = $signed({1'b0, qwave(5'd16 - {1'b0, angle[3:0]})});
		case (angle[5:4])
			2'd0:    v = fwd;
			2'd1:    v = -rev;
			2'd2:    v = -fwd;
			default: v = rev;
		endcase
		return v;
	endfunction

	function automatic logic signed [TRIG_W-1:0] trig_sin(input logic [ANGLE_W-1:0] angle);
		logic signed [TRIG_W-1:0] fwd;
		logic signed [TRIG_W-1:0] rev;
		logic signed [TRIG_W-1:0] v;
		fwd = $signed({1'b0, qwave({1'b0, angle[3:0]})});
		rev = $signed({1'b0, qwave(5'd16 - {1'b0, angle[3:0]})});
		case (angle[5:4])
			2'd0:    v = rev;
			2'd1:    v = fwd;
			2'd2:    v = -rev;
			default: v = -fwd;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/vrp_rotate.sv
`default_nettype none

module vrp_rotate import vrp_pkg::*; #(
	parameter int IN_W = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [IN_W-1:0]   p,
	input  logic signed [IN_W-1:0]   q,
	input  logic signed [IN_W-1:0]   r,
	input  logic signed [TRIG_W-1:0] cos_v,
	input  logic signed [TRIG_W-1:0] sin_v,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [IN_W:0]     a,
	output logic signed [IN_W:0]     b,
	output logic signed [IN_W-1:0]   r_out
);

	localparam int PROD_W = IN_W + TRIG_W;
	localparam int SUM_W  = PROD_W + 1;

	logic v_s1, v_s2, en_s1, en_s2;
	logic signed [PROD_W-1:0] cp_s1, sq_s1, cq_s1, sp_s1;
	logic signed [IN_W-1:0]   r_s1, r_s2;
	logic signed [SUM_W-1:0]  sum_a, sum_b;
	logic signed [IN_W:0]     a_s2, b_s2;

	// divide by 256, rounding toward zero
	function automatic logic signed [IN_W:0] trunc_div(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] adj;
		adj = v + (v[SUM_W-1] ? SUM_W'(TRIG_ONE - 1) : SUM_W'(0));
		return adj[IN_W+TRIG_SHIFT:TRIG_SHIFT];
	endfunction

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign sum_a = SUM_W'(cp_s1) - SUM_W'(sq_s1);
	assign sum_b = SUM_W'(cq_s1) + SUM_W'(sp_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			cp_s1 <= cos_v * p;
			sq_s1 <= sin_v * q;
			cq_s1 <= cos_v * q;
			sp_s1 <= sin_v * p;
			r_s1  <= r;
		end
		if (en_s2) begin
			a_s2 <= trunc_div(sum_a);
			b_s2 <= trunc_div(sum_b);
			r_s2 <= r_s1;
		end
	end

	assign out_valid = v_s2;
	assign a         = a_s2;
	assign b         = b_s2;
	assign r_out     = r_s2;

endmodule

`default_nettype wire

FILE: rtl/vrp_div.sv
`default_nettype none

module vrp_div import vrp_pkg::*; #(
	parameter int DEN_W = 18,
	parameter int PAY_W = 38
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [DEN_W-1:0] den,
	input  logic [PAY_W-1:0]        pay_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [QUOT_W-1:0]       scale,
	output logic                    behind,
	output logic [PAY_W-1:0]        pay_out
);

	localparam int STAGES = QUOT_W / DIV_BPS;
	localparam int IDX_W  = $clog2(QUOT_W);
	localparam logic [QUOT_W-1:0] DIV_NUM = QUOT_W'(PERSP_NUM);
	localparam logic [QUOT_W-1:0] DIV_ZERO_Q = QUOT_W'(PERSP_NUM + 1);

	logic [STAGES-1:0] v_s;
	logic [STAGES-1:0] en_s;
	logic [STAGES-1:0] behind_s;
	logic [QUOT_W-1:0] d_s   [STAGES];
	logic [QUOT_W-1:0] rem_s [STAGES];
	logic [QUOT_W-1:0] q_s   [STAGES];
	logic [PAY_W-1:0]  pay_s [STAGES];

	logic              behind_in;
	logic              big_in;
	logic [QUOT_W-1:0] d_in;

	// restoring division, DIV_BPS quotient bits per call
	function automatic logic [2*QUOT_W-1:0] div_step(
		input logic [QUOT_W-1:0] rem,
		input logic [QUOT_W-1:0] qin,
		input logic [QUOT_W-1:0] d,
		input int                base
	);
		logic [QUOT_W:0]   rr;
		logic [QUOT_W-1:0] qq;
		logic [IDX_W-1:0]  idx;
		rr = {1'b0, rem};
		qq = qin;
		for (int j = 0; j < DIV_BPS; j++) begin
			idx = IDX_W'(QUOT_W - 1 - base - j);
			rr  = {rr[QUOT_W-1:0], DIV_NUM[idx]};
			if (rr >= {1'b0, d}) begin
				rr      = rr - {1'b0, d};
				qq[idx] = 1'b1;
			end
		end
		return {rr[QUOT_W-1:0], qq};
	endfunction

	// denominators above the numerator give zero; a divisor of NUM+1 does that
	assign behind_in = den[DEN_W-1] || (den == '0);
	assign big_in    = den > $signed(DEN_W'(PERSP_NUM));
	assign d_in      = (behind_in || big_in) ? DIV_ZERO_Q : den[QUOT_W-1:0];
	assign in_ready  = en_s[0];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic                vi, bi, nxt;
		logic [QUOT_W-1:0]   ri, qi, di;
		logic [PAY_W-1:0]    pi;
		logic [2*QUOT_W-1:0] res;

		if (k == 0) begin : g_first
			assign vi = in_valid;
			assign ri = '0;
			assign qi = '0;
			assign di = d_in;
			assign bi = behind_in;
			assign pi = pay_in;
		end else begin : g_next
			assign vi = v_s[k-1];
			assign ri = rem_s[k-1];
			assign qi = q_s[k-1];
			assign di = d_s[k-1];
			assign bi = behind_s[k-1];
			assign pi = pay_s[k-1];
		end

		if (k == STAGES - 1) begin : g_last
			assign nxt = out_ready;
		end else begin : g_mid
			assign nxt = en_s[k+1];
		end

		assign en_s[k] = !v_s[k] || nxt;
		assign res     = div_step(ri, qi, di, k * DIV_BPS);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en_s[k]) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en_s[k]) begin
				rem_s[k]    <= res[2*QUOT_W-1:QUOT_W];
				q_s[k]      <= res[QUOT_W-1:0];
				d_s[k]      <= di;
				behind_s[k] <= bi;
				pay_s[k]    <= pi;
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign scale     = q_s[STAGES-1];
	assign behind    = behind_s[STAGES-1];
	assign pay_out   = pay_s[STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/vertex_rotate_project.sv
`default_nettype none

// Vertex rotate and perspective project.
// Input stream s_axis: one vertex per transaction, tdata = {pad, z, y, x},
// each COORD_WIDTH bits two's complement, x in the lowest bits.
// Output stream m_axis: one screen point per vertex, in order,
// tdata = {screen_y, screen_x}, tuser = behind_camera (screen point is zero).
// Configuration: cfg_we/cfg_index/cfg_data write angle_x, angle_y, angle_z,
// center_x, center_y, depth_offset (indexes 0..5); write only while the
// pipeline is empty.
// The pipeline is one input register, two stages for each of the three
// rotations, one denominator stage, five radix-8 restoring divider stages,
// one multiply stage and the output register. Throughput is one vertex per
// cycle while m_axis_tready stays high.
// Every stage holds while its successor is full and stalled, so a low
// m_axis_tready backs up only as far as the filled stages; s_axis_tready
// stays high while any bubble remains.
// Reset empties the pipeline and clears the configuration registers to zero
// angles, zero centers and zero depth offset.
module vertex_rotate_project import vrp_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// vertex_x, vertex_y, vertex_z, zero pad
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// screen_x, screen_y
	output logic [2*PIXEL_W-1:0]                   m_axis_tdata,
	// behind_camera
	output logic                                   m_axis_tuser,
	input  logic                                   cfg_we,
	input  logic [CFG_INDEX_W-1:0]                 cfg_index,
	input  logic [CFG_DATA_W-1:0]                  cfg_data
);

	localparam int W   = COORD_WIDTH;
	localparam int W1  = W + 1;
	localparam int W2  = W + 2;
	localparam int W3  = W + 3;
	localparam int DW  = ((W2 > DEPTH_W) ? W2 : DEPTH_W) + 2;
	localparam int PW  = QUOT_W + 1 + W3;

	logic [ANGLE_W-1:0]        angle_x_q, angle_y_q, angle_z_q;
	logic [PIXEL_W-1:0]        center_x_q, center_y_q;
	logic signed [DEPTH_W-1:0] depth_offset_q;
	logic signed [TRIG_W-1:0]  cos_x_q, sin_x_q, cos_y_q, sin_y_q, cos_z_q, sin_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_x_q      <= '0;
			angle_y_q      <= '0;
			angle_z_q      <= '0;
			center_x_q     <= '0;
			center_y_q     <= '0;
			depth_offset_q <= '0;
			cos_x_q        <= trig_cos('0);
			sin_x_q        <= trig_sin('0);
			cos_y_q        <= trig_cos('0);
			sin_y_q        <= trig_sin('0);
			cos_z_q        <= trig_cos('0);
			sin_z_q        <= trig_sin('0);
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ANGLE_X:      angle_x_q      <= cfg_data[ANGLE_W-1:0];
					REG_ANGLE_Y:      angle_y_q      <= cfg_data[ANGLE_W-1:0];
					REG_ANGLE_Z:      angle_z_q      <= cfg_data[ANGLE_W-1:0];
					REG_CENTER_X:     center_x_q     <= cfg_data[PIXEL_W-1:0];
					REG_CENTER_Y:     center_y_q     <= cfg_data[PIXEL_W-1:0];
					REG_DEPTH_OFFSET: depth_offset_q <= $signed(cfg_data[DEPTH_W-1:0]);
					default: ;
				endcase
			end
			cos_x_q <= trig_cos(angle_x_q);
			sin_x_q <= trig_sin(angle_x_q);
			cos_y_q <= trig_cos(angle_y_q);
			sin_y_q <= trig_sin(angle_y_q);
			cos_z_q <= trig_cos(angle_z_q);
			sin_z_q <= trig_sin(angle_z_q);
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	logic rx_in_ready, ry_in_ready, rz_in_ready, div_in_ready;
	logic rx_out_valid, ry_out_valid, rz_out_valid, div_out_valid;

	assign en_s4         = !v_s4 || m_axis_tready;
	assign en_s3         = !v_s3 || en_s4;
	assign en_s2         = !v_s2 || div_in_ready;
	assign en_s1         = !v_s1 || rx_in_ready;
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_axis_tvalid;
			if (en_s2) v_s2 <= rz_out_valid;
			if (en_s3) v_s3 <= div_out_valid;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// input register
	logic signed [W-1:0] vx_s1, vy_s1, vz_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			vx_s1 <= $signed(s_axis_tdata[W-1:0]);
			vy_s1 <= $signed(s_axis_tdata[2*W-1:W]);
			vz_s1 <= $signed(s_axis_tdata[3*W-1:2*W]);
		end
	end

	// rotate about X: (y, z)
	logic signed [W1-1:0] y1, z1;
	logic signed [W-1:0]  x0;

	vrp_rotate #(.IN_W(W)) u_rot_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rx_in_ready),
		.p         (vy_s1),
		.q         (vz_s1),
		.r         (vx_s1),
		.cos_v     (cos_x_q),
		.sin_v     (sin_x_q),
		.out_valid (rx_out_valid),
		.out_ready (ry_in_ready),
		.a         (y1),
		.b         (z1),
		.r_out     (x0)
	);

	// rotate about Y: (z, x)
	logic signed [W2-1:0] z2, x2;
	logic signed [W1-1:0] y1d;

	vrp_rotate #(.IN_W(W1)) u_rot_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx_out_valid),
		.in_ready  (ry_in_ready),
		.p         (z1),
		.q         (W1'(x0)),
		.r         (y1),
		.cos_v     (cos_y_q),
		.sin_v     (sin_y_q),
		.out_valid (ry_out_valid),
		.out_ready (rz_in_ready),
		.a         (z2),
		.b         (x2),
		.r_out     (y1d)
	);

	// rotate about Z: (x, y)
	logic signed [W3-1:0] x3, y3;
	logic signed [W2-1:0] z3;

	vrp_rotate #(.IN_W(W2)) u_rot_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (ry_out_valid),
		.in_ready  (rz_in_ready),
		.p         (x2),
		.q         (W2'(y1d)),
		.r         (z2),
		.cos_v     (cos_z_q),
		.sin_v     (sin_z_q),
		.out_valid (rz_out_valid),
		.out_ready (en_s2),
		.a         (x3),
		.b         (y3),
		.r_out     (z3)
	);

	// perspective denominator
	logic signed [DW-1:0] den_s2;
	logic [2*W3-1:0]      xy_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			den_s2 <= DW'(PERSP_BASE) - DW'(z3) - DW'(depth_offset_q);
			xy_s2  <= {x3, y3};
		end
	end

	logic [QUOT_W-1:0] div_scale;
	logic              div_behind;
	logic [2*W3-1:0]   div_xy;

	vrp_div #(.DEN_W(DW), .PAY_W(2*W3)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (div_in_ready),
		.den       (den_s2),
		.pay_in    (xy_s2),
		.out_valid (div_out_valid),
		.out_ready (en_s3),
		.scale     (div_scale),
		.behind    (div_behind),
		.pay_out   (div_xy)
	);

	// scale multiply
	logic signed [QUOT_W:0] scale_sgn;
	logic signed [W3-1:0]   x_div, y_div;
	logic signed [PW-1:0]   prod_x_s3, prod_y_s3;
	logic                   behind_s3;

	assign scale_sgn = $signed({1'b0, div_scale});
	assign x_div     = $signed(div_xy[2*W3-1:W3]);
	assign y_div     = $signed(div_xy[W3-1:0]);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_x_s3 <= scale_sgn * x_div;
			prod_y_s3 <= scale_sgn * y_div;
			behind_s3 <= div_behind;
		end
	end

	// truncate toward zero, add center, wrap
	logic signed [PW-1:0] adj_x, adj_y;
	logic [PIXEL_W-1:0]   screen_x_s4, screen_y_s4;
	logic                 behind_s4;

	assign adj_x = prod_x_s3 + (prod_x_s3[PW-1] ? PW'(TRIG_ONE - 1) : PW'(0));
	assign adj_y = prod_y_s3 + (prod_y_s3[PW-1] ? PW'(TRIG_ONE - 1) : PW'(0));

	always_ff @(posedge clk) begin
		if (en_s4) begin
			behind_s4 <= behind_s3;
			if (behind_s3) begin
				screen_x_s4 <= '0;
				screen_y_s4 <= '0;
			end else begin
				screen_x_s4 <= adj_x[TRIG_SHIFT+PIXEL_W-1:TRIG_SHIFT] + center_x_q;
				screen_y_s4 <= adj_y[TRIG_SHIFT+PIXEL_W-1:TRIG_SHIFT] + center_y_q;
			end
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {screen_y_s4, screen_x_s4};
	assign m_axis_tuser  = behind_s4;

	a_behind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("behind-camera result carries a nonzero screen point");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage is empty");

	a_div_drains: assert property (@(posedge clk) disable iff (!arst_n)
		div_out_valid && en_s3 |=> v_s3)
		else $error("divider result dropped at multiply stage");

endmodule

`default_nettype wire
